[hdl/timer_heap_scheduler_with_backoff_defines.svh]
// assertion macros for the timer heap scheduler
`ifndef TIMER_HEAP_SCHEDULER_WITH_BACKOFF_DEFINES_SVH
`define TIMER_HEAP_SCHEDULER_WITH_BACKOFF_DEFINES_SVH
// implication checked every cycle outside reset
`define THS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define THS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/ths_pkg.sv]
// shared types and constants of the timer heap scheduler
`timescale 1ns / 1ps
`default_nettype none
package ths_pkg;
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam int TIME_W = 48;
   localparam int IVL_W  = 32;
   localparam int ID_W   = 8;
   localparam int FAIL_W = 6;
   localparam logic [FAIL_W-1:0] FAIL_MAX = 6'd63;
   localparam int ENTRY_W = ID_W + TIME_W + IVL_W + IVL_W + FAIL_W;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] due;
      logic [IVL_W-1:0]  base;
      logic [IVL_W-1:0]  cur;
      logic [FAIL_W-1:0] fails;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;   // capture request beat
      logic new_entry;   // load work entry from insert
      logic rd_en;       // memory read
      logic rd_sel;      // 0 read parent/root, 1 read child
      logic cap_a;       // capture read data into slot a
      logic cap_b;       // capture chosen child into slot a, and its index
      logic wr_work;     // write work entry at cursor
      logic wr_a;        // write slot a at cursor
      logic move_up;     // cursor to parent
      logic move_dn;     // cursor to chosen child
      logic bo_start;    // start backoff
      logic bo_step;     // one backoff step
      logic fin_load;    // finalize finished root into work entry
      logic set_cur_root;
      logic set_cur_cnt;
      logic cnt_inc;
      logic make_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic full;
      logic empty;
      logic at_root;
      logic par_gt;      // parent due > work due
      logic chd_lt;      // chosen child due < work due
      logic has_l;
      logic has_r;
      logic bo_done;
   } sts_type;

   function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] t,
                                                input logic [IVL_W-1:0] d);
      logic [TIME_W:0] s;
      s = {1'b0, t} + {{(TIME_W-IVL_W+1){1'b0}}, d};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction
endpackage
`default_nettype wire

[hdl/ths_ram.sv]
// generic ram with separate write and read addresses and registered read
`timescale 1ns / 1ps
`default_nettype none
module ths_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   // write and registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[hdl/ths_datapath.sv]
// heap datapath: request registers, entry memory, compares, backoff
`timescale 1ns / 1ps
`default_nettype none
module ths_datapath import ths_pkg::*; #(
   parameter int HEAP_DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [IVL_W-1:0]  csr_wdata,
   input  wire logic [1:0]        req_op,
   input  wire logic [ID_W-1:0]   req_task_id,
   input  wire logic [IVL_W-1:0]  req_interval,
   input  wire logic              req_immediate,
   input  wire logic [TIME_W-1:0] req_now,
   input  wire logic              req_read_ok,
   output logic [1:0]             rsp_status,
   output logic                   rsp_due,
   output logic [ID_W-1:0]        rsp_due_id,
   output logic [TIME_W-1:0]      rsp_wait_ticks
);
   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

   logic [IVL_W-1:0] max_ff, ew_ff;
   logic [1:0] op_ff;
   logic [ID_W-1:0] id_ff;
   logic [IVL_W-1:0] ivl_ff;
   logic imm_ff, ok_ff;
   logic [TIME_W-1:0] now_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cur_ff;
   entry_type work_ff, a_ff;
   logic [IVL_W:0] bo_ff;
   logic [FAIL_W-1:0] bo_n_ff;
   logic [ENTRY_W-1:0] rdata;
   logic [CW-1:0] par, lch, rch, raddr_w;
   logic [AW-1:0] waddr;
   entry_type wdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= 32'd300000;
         ew_ff  <= 32'd1000;
      end else if (csr_we) begin
         if (csr_index) ew_ff <= csr_wdata;
         else max_ff <= csr_wdata;
      end
   end

   // heap index arithmetic
   assign par = (cur_ff - CW'(1)) >> 1;
   assign lch = {cur_ff[CW-2:0], 1'b1};
   assign rch = lch + CW'(1);
   assign raddr_w = cmd.rd_sel ? lch : (cmd.set_cur_root ? '0 : par);
   assign waddr = cur_ff[AW-1:0];
   assign wdata = cmd.wr_a ? a_ff : work_ff;

   ths_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_ram (
      .clock(clock), .we(cmd.wr_work | cmd.wr_a), .re(cmd.rd_en),
      .waddr(waddr), .raddr(raddr_w[AW-1:0]), .wdata(wdata), .rdata(rdata)
   );
   // second read port for the right child
   logic [ENTRY_W-1:0] rdata_r;
   ths_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_ram_r (
      .clock(clock), .we(cmd.wr_work | cmd.wr_a), .re(cmd.rd_en),
      .waddr(waddr), .raddr(rch[AW-1:0]), .wdata(wdata), .rdata(rdata_r)
   );

   entry_type rd_e, rd_r;
   assign rd_e = rdata;
   assign rd_r = rdata_r;

   // status
   assign sts.op = op_ff;
   assign sts.full = (cnt_ff == DEPTH_C);
   assign sts.empty = (cnt_ff == '0);
   assign sts.at_root = (cur_ff == '0);
   assign sts.par_gt = (a_ff.due > work_ff.due);
   assign sts.chd_lt = (a_ff.due < work_ff.due);
   assign sts.has_l = ({1'b0, lch} < {1'b0, cnt_ff});
   assign sts.has_r = ({1'b0, rch} < {1'b0, cnt_ff});
   assign sts.bo_done = (bo_n_ff == '0) || (bo_ff >= {1'b0, max_ff});

   // sift-down choice: smaller child, left one on a tie
   entry_type pick;
   always_comb begin
      pick = rd_e;
      if (sts.has_r && (rd_r.due < rd_e.due)) pick = rd_r;
   end
   logic [CW-1:0] pick_idx;
   always_comb begin
      pick_idx = lch;
      if (sts.has_r && (rd_r.due < rd_e.due)) pick_idx = rch;
   end
   logic [CW-1:0] dn_ff;

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         cur_ff <= '0;
      end else begin
         if (cmd.cnt_inc) cnt_ff <= cnt_ff + CW'(1);
         if (cmd.set_cur_cnt) cur_ff <= cnt_ff;
         else if (cmd.set_cur_root) cur_ff <= '0;
         else if (cmd.move_up) cur_ff <= par;
         else if (cmd.move_dn) cur_ff <= dn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff <= req_op; id_ff <= req_task_id; ivl_ff <= req_interval;
         imm_ff <= req_immediate; now_ff <= req_now; ok_ff <= req_read_ok;
      end
      if (cmd.new_entry) begin
         work_ff.id <= id_ff; work_ff.base <= ivl_ff; work_ff.cur <= ivl_ff;
         work_ff.fails <= '0;
         work_ff.due <= imm_ff ? now_ff : add_sat(now_ff, ivl_ff);
      end
      if (cmd.cap_a) a_ff <= rd_e;
      if (cmd.cap_b) begin
         dn_ff <= pick_idx;
         a_ff <= pick;
      end
      if (cmd.bo_start) begin
         work_ff <= a_ff;
         bo_ff <= {1'b0, a_ff.base};
         bo_n_ff <= (a_ff.fails < FAIL_MAX) ? a_ff.fails + FAIL_W'(1) : a_ff.fails;
      end else if (cmd.bo_step) begin
         bo_ff <= {bo_ff[IVL_W-1:0], 1'b0};
         bo_n_ff <= bo_n_ff - FAIL_W'(1);
      end
      if (cmd.fin_load) begin
         if (ok_ff) begin
            work_ff.fails <= '0;
            work_ff.cur <= work_ff.base;
            work_ff.due <= add_sat(now_ff, work_ff.base);
         end else begin
            work_ff.fails <= (work_ff.fails < FAIL_MAX) ?
                             work_ff.fails + FAIL_W'(1) : work_ff.fails;
            if (bo_ff >= {1'b0, max_ff}) begin
               work_ff.cur <= max_ff;
               work_ff.due <= add_sat(now_ff, max_ff);
            end else begin
               work_ff.cur <= bo_ff[IVL_W-1:0];
               work_ff.due <= add_sat(now_ff, bo_ff[IVL_W-1:0]);
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.make_rsp) begin
         rsp_status <= ST_OK; rsp_due <= 1'b0; rsp_due_id <= '0; rsp_wait_ticks <= '0;
         case (op_ff)
            OP_INSERT: if (sts.full) rsp_status <= ST_FULL;
            OP_QUERY: begin
               if (sts.empty) begin
                  rsp_status <= ST_EMPTY;
                  rsp_wait_ticks <= {{(TIME_W-IVL_W){1'b0}}, ew_ff};
               end else begin
                  rsp_due_id <= a_ff.id;
                  if (a_ff.due <= now_ff) rsp_due <= 1'b1;
                  else rsp_wait_ticks <= a_ff.due - now_ff;
               end
            end
            OP_FINISH: begin
               if (sts.empty) rsp_status <= ST_EMPTY;
               else rsp_due_id <= a_ff.id;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

[hdl/ths_ctrl.sv]
// heap controller state machine
`timescale 1ns / 1ps
`default_nettype none
module ths_ctrl import ths_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   input  wire sts_type sts,
   output cmd_type   cmd
);
   localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RDROOT = 4'd2,
      S_ROOTW = 4'd3, S_UPRD = 4'd4, S_UPW = 4'd5, S_UPCMP = 4'd6,
      S_BO = 4'd7, S_FIN = 4'd8, S_DNRD = 4'd9, S_DNW = 4'd10,
      S_DNCMP = 4'd11, S_RSP = 4'd12, S_INS = 4'd13, S_RSPQ = 4'd14;
   // backoff phase marks
   localparam logic [1:0] K_NONE = 2'd0, K_BO_START = 2'd2, K_BO_RUN = 2'd3;

   logic [3:0] state_ff, state_in;
   logic rv_ff, rv_in;
   logic [1:0] kind_ff, kind_in;

   assign rsp_valid = rv_ff;
   assign req_ready = (state_ff == S_IDLE) && (!rv_ff || rsp_ready);

   // next state and commands
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rv_in = rv_ff && !rsp_ready;
      kind_in = kind_ff;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.latch_req = 1'b1; state_in = S_DEC;
         end
         S_DEC: begin
            if (sts.op == OP_INSERT && !sts.full) begin
               cmd.new_entry = 1'b1; cmd.set_cur_cnt = 1'b1; state_in = S_INS;
            end else if ((sts.op == OP_QUERY || sts.op == OP_FINISH) && !sts.empty) begin
               cmd.rd_en = 1'b1; cmd.set_cur_root = 1'b1; state_in = S_RDROOT;
            end else state_in = S_RSPQ;
         end
         S_INS: begin
            cmd.wr_work = 1'b1;
            state_in = sts.at_root ? S_RSPQ : S_UPRD;
         end
         S_UPRD: begin cmd.rd_en = 1'b1; state_in = S_UPW; end
         S_UPW: begin cmd.cap_a = 1'b1; state_in = S_UPCMP; end
         S_UPCMP: begin
            if (sts.par_gt) begin
               cmd.wr_a = 1'b1; cmd.move_up = 1'b1; state_in = S_INS;
            end else state_in = S_RSPQ;
         end
         S_RDROOT: state_in = S_ROOTW;
         S_ROOTW: begin
            cmd.cap_a = 1'b1;
            state_in = (sts.op == OP_FINISH) ? S_BO : S_RSPQ;
            kind_in = K_BO_START;
         end
         S_BO: begin
            if (kind_ff == K_BO_START) begin
               cmd.bo_start = 1'b1; cmd.make_rsp = 1'b1; kind_in = K_BO_RUN;
            end else if (sts.bo_done) begin
               state_in = S_FIN;
            end else cmd.bo_step = 1'b1;
         end
         S_FIN: begin cmd.fin_load = 1'b1; state_in = S_DNRD; end
         S_DNRD: begin
            if (sts.has_l) begin
               cmd.rd_en = 1'b1; cmd.rd_sel = 1'b1; state_in = S_DNW;
            end else begin cmd.wr_work = 1'b1; state_in = S_RSP; end
         end
         S_DNW: begin cmd.cap_b = 1'b1; state_in = S_DNCMP; end
         S_DNCMP: begin
            if (sts.chd_lt) begin
               cmd.wr_a = 1'b1; cmd.move_dn = 1'b1; state_in = S_DNRD;
            end else begin cmd.wr_work = 1'b1; state_in = S_RSP; end
         end
         // count grows once per stored insert, after the full check
         S_RSPQ: begin
            cmd.make_rsp = 1'b1; state_in = S_RSP;
            cmd.cnt_inc = (sts.op == OP_INSERT) && !sts.full;
         end
         S_RSP: if (!rv_ff || rsp_ready) begin
            rv_in = 1'b1; state_in = S_IDLE; kind_in = K_NONE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; kind_ff <= K_NONE;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; kind_ff <= kind_in;
      end
   end
endmodule
`default_nettype wire

[hdl/timer_heap_scheduler_with_backoff.sv]
// Timer heap scheduler top level. An insert sifts up from the new leaf; a finish
// doubles the backoff interval up to failures + 1 times (at most 63, ends at the
// cap), then sifts the root down. One beat at a time: the next beat can be
// accepted in the cycle rsp_valid rises if rsp_ready is high. Sync reset empties
// heap.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_heap_scheduler_with_backoff_defines.svh"
module timer_heap_scheduler_with_backoff import ths_pkg::*; #(
   parameter int HEAP_DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_op,
   input  wire logic [ID_W-1:0]   req_task_id,
   input  wire logic [IVL_W-1:0]  req_interval,
   input  wire logic              req_immediate,
   input  wire logic [TIME_W-1:0] req_now,
   input  wire logic              req_read_ok,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_status,
   output logic                   rsp_due,
   output logic [ID_W-1:0]        rsp_due_id,
   output logic [TIME_W-1:0]      rsp_wait_ticks,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [IVL_W-1:0]  csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   ths_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   ths_datapath #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_op(req_op), .req_task_id(req_task_id), .req_interval(req_interval),
      .req_immediate(req_immediate), .req_now(req_now), .req_read_ok(req_read_ok),
      .rsp_status(rsp_status), .rsp_due(rsp_due), .rsp_due_id(rsp_due_id),
      .rsp_wait_ticks(rsp_wait_ticks)
   );

   // checks
   `THS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted beat must block next")
   `THS_ASSERT_IMP(a_due_no_wait, clock, reset, rsp_valid && rsp_due, rsp_wait_ticks == '0, "due beat carries wait")
   `THS_ASSERT_IMP(a_full_status, clock, reset, rsp_valid && rsp_status == ST_FULL, !rsp_due, "full beat marked due")
endmodule
`default_nettype wire

[test/tb.sv]
// self-checking testbench for the timer heap scheduler with backoff
`timescale 1ns / 1ps
module tb;
   import ths_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic CSR_MAX_IVL = 1'b0;
   localparam logic CSR_EMPTY_WAIT = 1'b1;
   localparam int DEPTH = 64;

   typedef struct packed {
      logic [1:0]        op;
      logic [ID_W-1:0]   id;
      logic [IVL_W-1:0]  ivl;
      logic              imm;
      logic [TIME_W-1:0] now;
      logic              ok;
   } sched_req_t;

   typedef struct packed {
      logic [1:0]        status;
      logic              due;
      logic [ID_W-1:0]   due_id;
      logic [TIME_W-1:0] wait_ticks;
   } sched_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_op = '0;
   logic [ID_W-1:0] req_task_id = '0;
   logic [IVL_W-1:0] req_interval = '0;
   logic req_immediate = 1'b0;
   logic [TIME_W-1:0] req_now = '0;
   logic req_read_ok = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_due;
   logic [ID_W-1:0] rsp_due_id;
   logic [TIME_W-1:0] rsp_wait_ticks;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [IVL_W-1:0] csr_wdata = '0;

   timer_heap_scheduler_with_backoff DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_task_id(req_task_id), .req_interval(req_interval),
      .req_immediate(req_immediate), .req_now(req_now), .req_read_ok(req_read_ok),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_due(rsp_due), .rsp_due_id(rsp_due_id), .rsp_wait_ticks(rsp_wait_ticks),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // shadow heap
   logic [ID_W-1:0]   hp_id[DEPTH];
   logic [TIME_W-1:0] hp_due[DEPTH];
   logic [IVL_W-1:0]  hp_base[DEPTH];
   logic [IVL_W-1:0]  hp_cur[DEPTH];
   logic [FAIL_W-1:0] hp_fails[DEPTH];
   int hp_count = 0;
   logic [IVL_W-1:0] cap_ivl = 32'd300000;
   logic [IVL_W-1:0] idle_wait = 32'd1000;

   sched_req_t pending_q[$];
   sched_rsp_t expected_q[$];
   int errors = 0;
   bit req_taken = 0;
   bit quiet = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   logic [TIME_W-1:0] tnow = '0;

   function automatic logic [TIME_W-1:0] due_at(input logic [TIME_W-1:0] t,
                                                input logic [IVL_W-1:0] d);
      logic [TIME_W:0] s;
      s = {1'b0, t} + {{(TIME_W-IVL_W+1){1'b0}}, d};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   task automatic swap_slots(input int a, input int b);
      logic [ID_W-1:0] i8;
      logic [TIME_W-1:0] t;
      logic [IVL_W-1:0] v;
      logic [FAIL_W-1:0] f;
      i8 = hp_id[a]; hp_id[a] = hp_id[b]; hp_id[b] = i8;
      t = hp_due[a]; hp_due[a] = hp_due[b]; hp_due[b] = t;
      v = hp_base[a]; hp_base[a] = hp_base[b]; hp_base[b] = v;
      v = hp_cur[a]; hp_cur[a] = hp_cur[b]; hp_cur[b] = v;
      f = hp_fails[a]; hp_fails[a] = hp_fails[b]; hp_fails[b] = f;
   endtask

   // heap update and expected response for one accepted beat
   task automatic schedule_step(input sched_req_t r, output sched_rsp_t e);
      int k, p, m, l, rt, f;
      bit done;
      logic [63:0] b;
      e = '0;
      case (r.op)
         OP_INSERT: begin
            if (hp_count >= DEPTH) begin
               e.status = ST_FULL;
            end else begin
               k = hp_count;
               hp_id[k] = r.id;
               hp_base[k] = r.ivl;
               hp_cur[k] = r.ivl;
               hp_fails[k] = '0;
               hp_due[k] = r.imm ? r.now : due_at(r.now, r.ivl);
               hp_count++;
               done = 0;
               while (k > 0 && !done) begin
                  p = (k - 1) / 2;
                  if (hp_due[k] < hp_due[p]) begin
                     swap_slots(k, p);
                     k = p;
                  end else begin
                     done = 1;
                  end
               end
            end
         end
         OP_QUERY: begin
            if (hp_count == 0) begin
               e.status = ST_EMPTY;
               e.wait_ticks = {{(TIME_W-IVL_W){1'b0}}, idle_wait};
            end else begin
               e.due_id = hp_id[0];
               if (hp_due[0] <= r.now) e.due = 1'b1;
               else e.wait_ticks = hp_due[0] - r.now;
            end
         end
         OP_FINISH: begin
            if (hp_count == 0) begin
               e.status = ST_EMPTY;
            end else begin
               e.due_id = hp_id[0];
               if (r.ok) begin
                  hp_fails[0] = '0;
                  hp_cur[0] = hp_base[0];
               end else begin
                  // double once per failure, stop at the cap
                  f = hp_fails[0];
                  if (f < FAIL_MAX) f++;
                  hp_fails[0] = f[FAIL_W-1:0];
                  b = {32'd0, hp_base[0]};
                  done = 0;
                  for (int i = 0; i < f && !done; i++) begin
                     b = b * 2;
                     if (b >= {32'd0, cap_ivl}) begin
                        b = {32'd0, cap_ivl};
                        done = 1;
                     end
                  end
                  hp_cur[0] = b[IVL_W-1:0];
               end
               hp_due[0] = due_at(r.now, hp_cur[0]);
               k = 0;
               done = 0;
               while (!done) begin
                  m = k;
                  l = 2 * k + 1;
                  rt = 2 * k + 2;
                  if (l < hp_count && hp_due[l] < hp_due[m]) m = l;
                  if (rt < hp_count && hp_due[rt] < hp_due[m]) m = rt;
                  if (m == k) done = 1;
                  else begin
                     swap_slots(k, m);
                     k = m;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver
   always @(negedge clock) begin
      sched_req_t it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0 && !quiet) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            it = pending_q.pop_front();
            req_op <= it.op;
            req_task_id <= it.id;
            req_interval <= it.ivl;
            req_immediate <= it.imm;
            req_now <= it.now;
            req_read_ok <= it.ok;
            req_valid <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 0;
   end

   // response ready with random stalls and requested long hold-off
   always @(negedge clock) begin
      int r;
      if (hold_left > 0) begin
         hold_left--;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (!quiet) begin
         r = $urandom_range(0, 99);
         if (r < 15) stall_left = $urandom_range(1, 3);
         else if (r < 18) stall_left = $urandom_range(10, 40);
      end
      rsp_ready <= !reset && hold_left == 0 && stall_left == 0;
   end

   // accepted request beats feed the shadow heap
   always @(posedge clock) begin
      sched_req_t it;
      sched_rsp_t e;
      if (!reset && req_valid && req_ready) begin
         it = '{req_op, req_task_id, req_interval, req_immediate, req_now, req_read_ok};
         schedule_step(it, e);
         expected_q.insert(expected_q.size(), e);
         req_taken = 1;
      end
   end

   // response checker
   always @(posedge clock) begin
      sched_rsp_t e;
      sched_rsp_t got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_due, rsp_due_id, rsp_wait_ticks};
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat: %p", got);
         end else begin
            e = expected_q.pop_front();
            if (got !== e) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp status %0d due %0d id %0d wait %0d, got %0d %0d %0d %0d",
                     e.status, e.due, e.due_id, e.wait_ticks,
                     got.status, got.due, got.due_id, got.wait_ticks);
            end
         end
      end
   end

   task automatic add_req(input logic [1:0] op, input logic [ID_W-1:0] id,
                          input logic [IVL_W-1:0] ivl, input logic imm,
                          input logic [TIME_W-1:0] now, input logic ok);
      sched_req_t it;
      it = '{op, id, ivl, imm, now, ok};
      pending_q.insert(pending_q.size(), it);
   endtask

   // random beat of the requested kind
   task automatic add_random(input logic [1:0] op);
      logic [TIME_W-1:0] now;
      logic [IVL_W-1:0] ivl;
      tnow = tnow + TIME_W'($urandom_range(0, 20));
      now = ($urandom_range(0, 19) == 0) ? TIME_W'({$urandom, $urandom}) : tnow;
      ivl = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 40);
      if (ivl == 0) ivl = 1;
      add_req(op, ID_W'($urandom), ivl, 1'($urandom), now, 1'($urandom));
   endtask

   // wait for every beat to be sent and answered, then let the block settle
   task automatic drain();
      while (pending_q.size() > 0 || req_valid || expected_q.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [IVL_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_MAX_IVL) cap_ivl = val;
      else idle_wait = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int r;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty heap at reset defaults, unused op with all bits set
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, '0, 1'b0);
      add_req(OP_FINISH, 8'h00, 32'd1, 1'b0, '0, 1'b0);
      add_req(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1, TIME_MAX, 1'b1);
      drain();
      csr_write(CSR_EMPTY_WAIT, 32'hFFFF_FFFF);
      add_req(OP_QUERY, 8'h12, 32'd7, 1'b1, TIME_MAX, 1'b1);
      drain();
      csr_write(CSR_EMPTY_WAIT, 32'd1);
      csr_write(CSR_MAX_IVL, 32'd1);
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, 48'd5, 1'b0);
      // single entry: saturated due time, cap of one tick; later inserts grow the heap
      add_req(OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b0, TIME_MAX - 5, 1'b0);
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, TIME_MAX - 1, 1'b0);
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, TIME_MAX, 1'b0);
      add_req(OP_FINISH, 8'h00, 32'd1, 1'b0, '0, 1'b0);
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, '0, 1'b0);
      add_req(OP_FINISH, 8'h00, 32'd1, 1'b0, 48'd100, 1'b1);
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, 48'd50, 1'b0);
      add_req(OP_INSERT, 8'h00, 32'd1, 1'b1, '0, 1'b1);
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, '0, 1'b0);
      add_req(OP_FINISH, 8'h00, 32'd1, 1'b0, 48'd3, 1'b1);
      add_req(OP_INSERT, 8'h55, 32'd10, 1'b0, 48'd4, 1'b0);
      add_req(OP_INSERT, 8'hAA, 32'd6, 1'b1, 48'd8, 1'b0);
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, 48'd7, 1'b0);
      add_req(OP_FINISH, 8'h00, 32'd1, 1'b0, 48'd8, 1'b0);
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, 48'd9, 1'b0);
      drain();

      // long failure streak on the root, counter saturates, then recovery
      csr_write(CSR_MAX_IVL, 32'hFFFF_FFFF);
      quiet = 1;
      for (int i = 0; i < 70; i++) add_req(OP_FINISH, 8'h00, 32'd1, 1'b0, 48'd20 + i, 1'b0);
      add_req(OP_QUERY, 8'h00, 32'd1, 1'b0, 48'd100, 1'b0);
      add_req(OP_FINISH, 8'h00, 32'd1, 1'b0, 48'd100, 1'b1);
      drain();
      quiet = 0;

      // fill the heap with a random mix, refused inserts once full
      csr_write(CSR_MAX_IVL, 32'd5000);
      tnow = 48'd200;
      for (int i = 0; i < 110; i++) begin
         r = $urandom_range(0, 99);
         if (r < 75) add_random(OP_INSERT);
         else if (r < 88) add_random(OP_QUERY);
         else add_random(OP_FINISH);
      end
      drain();

      // full heap: receiver holds off while the sender keeps offering
      csr_write(CSR_MAX_IVL, 32'd300000);
      hold_left = 400;
      for (int i = 0; i < 220; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) add_random(OP_INSERT);
         else if (r < 50) add_random(OP_QUERY);
         else if (r < 95) add_random(OP_FINISH);
         else add_random(OP_UNUSED);
      end
      drain();
      repeat (200) @(posedge clock);

      if (errors == 0 && expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Some tests failed");
      $finish;
   end
endmodule

[timer_heap_scheduler_with_backoff.f]
+incdir+hdl
hdl/ths_pkg.sv
hdl/ths_ram.sv
hdl/ths_datapath.sv
hdl/ths_ctrl.sv
hdl/timer_heap_scheduler_with_backoff.sv
test/tb.sv
